// ===== sv/lzss_wd_pkg.sv =====
`default_nettype none
package lzss_wd_pkg;

    localparam int unsigned DATA_W           = 8;
    localparam int unsigned WINDOW_BYTES_DEF = 1024;
    localparam int unsigned MAX_COPY         = 63;
    localparam int unsigned LEN_W            = 6;
    localparam int unsigned USED_W           = 4;
    localparam int unsigned PHASE_W          = 2;

    localparam logic [DATA_W-1:0]  FILL_BYTE      = 8'h20;
    localparam logic [USED_W-1:0]  FLAGS_USED_RST = 4'd7;
    localparam logic [USED_W-1:0]  FLAGS_PER_BYTE = 4'd8;

    // token phase codes
    localparam logic [PHASE_W-1:0] PH_NEXT = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TOK  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_REF2 = 2'd2;

    typedef struct packed {
        logic clear;
        logic literal;
        logic hold;
        logic start_ref;
        logic gather;
        logic prep;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic len_zero;
        logic cnt_last;
        logic slot_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== sv/lzss_window_decompressor_top.sv =====
// literal: result in the output register in the cycle after the request is accepted
// flag byte and first reference byte: consumed with no result
// reference of length L: gather, drain, prep, then emit at one byte a cycle while the output accepts,
// bound by the single read port of the window and copy buffer
// reset: i_rst_n synchronous active low; no clearing pass, unwritten window bytes read as spaces
`default_nettype none
module lzss_window_decompressor_top #(
    parameter int unsigned WINDOW_BYTES = lzss_wd_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [lzss_wd_pkg::DATA_W-1:0]    s_axis_tdata,  // in_byte
    input  wire logic                              s_axis_tuser,  // stream_start
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [lzss_wd_pkg::DATA_W-1:0]         m_axis_tdata,  // out_byte
    output logic                                   m_axis_tlast   // run_last
);
    import lzss_wd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lzss_wd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_data  (s_axis_tdata),
        .i_s_start (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    lzss_wd_dp #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_data  (s_axis_tdata),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_m_data  (m_axis_tdata),
        .o_m_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== sv/lzss_wd_ctrl.sv =====
`default_nettype none
module lzss_wd_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_valid,
    input  wire logic [lzss_wd_pkg::DATA_W-1:0]    i_s_data,
    input  wire logic                              i_s_start,
    output logic                                   o_s_ready,
    input  wire lzss_wd_pkg::t_dp_stat             i_stat,
    output lzss_wd_pkg::t_dp_cmd                   o_cmd
);
    import lzss_wd_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GATHER = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_PREP   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [USED_W-1:0]  r_used, n_used;
    logic [DATA_W-1:0]  r_flags, n_flags;

    logic               acc;
    logic [PHASE_W-1:0] ph_eff;
    logic [USED_W-1:0]  used_eff;
    logic [USED_W-1:0]  used_inc;
    logic [DATA_W-1:0]  flags_eff;
    logic [DATA_W-1:0]  flags_sh;

    assign o_s_ready = (r_state == ST_IDLE) && i_stat.slot_free;
    assign acc       = i_s_valid && o_s_ready;

    assign ph_eff    = i_s_start ? PH_NEXT : r_phase;
    assign used_eff  = i_s_start ? FLAGS_USED_RST : r_used;
    assign flags_eff = i_s_start ? '0 : r_flags;
    assign used_inc  = used_eff + USED_W'(1);
    assign flags_sh  = {flags_eff[DATA_W-2:0], 1'b0};

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_used  = r_used;
        n_flags = r_flags;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    o_cmd.clear = i_s_start;
                    n_phase     = ph_eff;
                    n_used      = used_eff;
                    n_flags     = flags_eff;
                    if (ph_eff == PH_REF2) begin
                        o_cmd.start_ref = 1'b1;
                        n_phase         = PH_NEXT;
                        if (!i_stat.len_zero) begin
                            n_state = ST_GATHER;
                        end
                    end else if (ph_eff == PH_TOK) begin
                        if (flags_eff[DATA_W-1]) begin
                            o_cmd.hold = 1'b1;
                            n_phase    = PH_REF2;
                        end else begin
                            o_cmd.literal = 1'b1;
                            n_phase       = PH_NEXT;
                        end
                    end else if (used_inc >= FLAGS_PER_BYTE) begin
                        n_flags = i_s_data;
                        n_used  = '0;
                        n_phase = PH_TOK;
                    end else begin
                        n_flags = flags_sh;
                        n_used  = used_inc;
                        if (flags_sh[DATA_W-1]) begin
                            o_cmd.hold = 1'b1;
                            n_phase    = PH_REF2;
                        end else begin
                            o_cmd.literal = 1'b1;
                            n_phase       = PH_NEXT;
                        end
                    end
                end
            end
            ST_GATHER: begin
                o_cmd.gather = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = i_stat.slot_free;
                if (i_stat.slot_free && i_stat.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_NEXT;
            r_used  <= FLAGS_USED_RST;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_used  <= n_used;
            r_flags <= n_flags;
        end
    end

`ifndef NO_ASSERTIONS
    a_gather_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GATHER) && i_stat.cnt_last |=> (r_state == ST_DRAIN))
        else $error("gather did not end after last read");
    a_drain_prep_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> (r_state == ST_PREP) ##1 (r_state == ST_EMIT))
        else $error("copy setup sequence broken");
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FLAGS_PER_BYTE)
        else $error("flag counter out of range");
`endif

endmodule
`default_nettype wire

// ===== sv/lzss_wd_dp.sv =====
`default_nettype none
module lzss_wd_dp #(
    parameter int unsigned WINDOW_BYTES = lzss_wd_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [lzss_wd_pkg::DATA_W-1:0]    i_s_data,
    input  wire lzss_wd_pkg::t_dp_cmd              i_cmd,
    output lzss_wd_pkg::t_dp_stat                  o_stat,
    input  wire logic                              i_m_ready,
    output logic                                   o_m_valid,
    output logic [lzss_wd_pkg::DATA_W-1:0]         o_m_data,
    output logic                                   o_m_last
);
    import lzss_wd_pkg::*;

    localparam int unsigned AW = $clog2(WINDOW_BYTES);

    logic [DATA_W-1:0] r_win_mem [WINDOW_BYTES];
    logic [DATA_W-1:0] r_buf_mem [MAX_COPY];

    logic [AW-1:0]     r_wp, n_wp;
    logic              r_wrapped, n_wrapped;
    logic [DATA_W-1:0] r_held;
    logic [AW-1:0]     r_src;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_win_q;
    logic              r_win_ok;
    logic              r_gw_en;
    logic [LEN_W-1:0]  r_gw_idx;
    logic [DATA_W-1:0] r_buf_q;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;

    logic              slot_free;
    logic              cnt_last;
    logic [AW-1:0]     wp_base;
    logic              wrapped_base;
    logic              win_we;
    logic [DATA_W-1:0] win_wdata;
    logic [AW-1:0]     ref_dist;
    logic [AW-1:0]     gaddr;
    logic [LEN_W-1:0]  buf_raddr;

    assign slot_free = !r_out_valid || i_m_ready;
    assign cnt_last  = (r_cnt == (r_len - LEN_W'(1)));

    assign o_stat.len_zero  = (r_held[DATA_W-1:2] == '0);
    assign o_stat.cnt_last  = cnt_last;
    assign o_stat.slot_free = slot_free;

    assign wp_base      = i_cmd.clear ? '0 : r_wp;
    assign wrapped_base = i_cmd.clear ? 1'b0 : r_wrapped;
    assign win_we       = i_cmd.literal || i_cmd.emit;
    assign win_wdata    = i_cmd.literal ? i_s_data : r_buf_q;
    assign ref_dist     = AW'({r_held[1:0], i_s_data});
    assign gaddr        = r_src + AW'(r_cnt);

    always_comb begin
        if (i_cmd.prep) begin
            buf_raddr = '0;
        end else if (i_cmd.emit) begin
            buf_raddr = r_cnt + LEN_W'(1);
        end else begin
            buf_raddr = r_cnt;
        end
    end

    always_comb begin
        n_wp      = wp_base;
        n_wrapped = wrapped_base;
        if (win_we) begin
            n_wp = wp_base + AW'(1);
            if (wp_base == '1) begin
                n_wrapped = 1'b1;
            end
        end
    end

    // history window
    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_win_mem[wp_base] <= win_wdata;
        end
        if (i_cmd.gather) begin
            r_win_q <= r_win_mem[gaddr];
        end
    end

    // copy buffer
    always_ff @(posedge i_clk) begin
        if (r_gw_en) begin
            r_buf_mem[r_gw_idx] <= r_win_ok ? r_win_q : FILL_BYTE;
        end
        r_buf_q <= r_buf_mem[buf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hold) begin
            r_held <= i_s_data;
        end
        if (i_cmd.start_ref) begin
            r_src <= r_wp - ref_dist;
            r_len <= r_held[DATA_W-1:2];
        end
        if (i_cmd.gather) begin
            r_win_ok <= r_wrapped || (gaddr < r_wp);
            r_gw_idx <= r_cnt;
        end
        if (win_we) begin
            r_out_data <= win_wdata;
            r_out_last <= i_cmd.literal || cnt_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_cnt       <= '0;
            r_gw_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp      <= n_wp;
            r_wrapped <= n_wrapped;
            r_gw_en   <= i_cmd.gather;
            if (i_cmd.start_ref || i_cmd.prep) begin
                r_cnt <= '0;
            end else if (i_cmd.gather || i_cmd.emit) begin
                r_cnt <= r_cnt + LEN_W'(1);
            end
            if (win_we) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_last  = r_out_last;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_we |-> slot_free)
        else $error("output register overwritten");
    a_single_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.literal && (i_cmd.emit || i_cmd.gather)))
        else $error("literal during copy");
`endif

endmodule
`default_nettype wire
